// ----- rtl/rabs_pkg.sv -----
// shared constants and types for the running average background subtractor
`timescale 1ns / 1ps

package rabs_pkg;

  // default sizing of the model store
  localparam int MAX_PIXELS_DEF = 524288;
  localparam int MODEL_FRAC_DEF = 8;

  // configuration port
  localparam int CFG_DATA_W  = 20;
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_BLEND_WEIGHT     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_DIFF_THRESHOLD   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_PIXELS_PER_FRAME = 2'd2;

  // register widths and reset values
  localparam int BLEND_W = 16;
  localparam int THRESH_W = 8;
  localparam int FRAME_W = 20;
  localparam logic [BLEND_W-1:0]  BLEND_RESET  = 16'd3277;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 8'd16;
  localparam logic [FRAME_W-1:0]  FRAME_RESET  = 20'd307200;

  // pixel and mask widths
  localparam int PIX_W = 8;
  localparam logic [PIX_W-1:0] MASK_FG = 8'hff;
  localparam logic [PIX_W-1:0] MASK_BG = 8'h00;

  // bt.601 luma weights in q2.14, rounded
  localparam int GRAY_SUM_W = 22;
  localparam int GRAY_SHIFT = 14;
  localparam logic [GRAY_SUM_W-1:0] GRAY_W_BLUE  = 22'd1868;
  localparam logic [GRAY_SUM_W-1:0] GRAY_W_GREEN = 22'd9617;
  localparam logic [GRAY_SUM_W-1:0] GRAY_W_RED   = 22'd4899;
  localparam logic [GRAY_SUM_W-1:0] GRAY_ROUND   = 22'd8192;

  // flags that travel with each pixel through the pipe
  typedef struct packed {
    logic loaded;
    logic last;
  } pix_ctrl_t;

endpackage

// ----- rtl/rabs_ram.sv -----
// generic single-port-write, single-port-read ram with registered read
`timescale 1ns / 1ps

module rabs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic                                  rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data holds while no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/rabs_gray.sv -----
// bgr to 8-bit gray conversion with bt.601 weights
`timescale 1ns / 1ps

module rabs_gray (
  input  logic [rabs_pkg::PIX_W-1:0] blue,
  input  logic [rabs_pkg::PIX_W-1:0] green,
  input  logic [rabs_pkg::PIX_W-1:0] red,
  output logic [rabs_pkg::PIX_W-1:0] gray
);

  localparam int SW = rabs_pkg::GRAY_SUM_W;

  logic [SW-1:0] sum;

  // weighted sum plus half, then drop the fraction
  always_comb begin
    sum = {{(SW - rabs_pkg::PIX_W){1'b0}}, blue}  * rabs_pkg::GRAY_W_BLUE
        + {{(SW - rabs_pkg::PIX_W){1'b0}}, green} * rabs_pkg::GRAY_W_GREEN
        + {{(SW - rabs_pkg::PIX_W){1'b0}}, red}   * rabs_pkg::GRAY_W_RED
        + rabs_pkg::GRAY_ROUND;
    gray = sum[rabs_pkg::GRAY_SHIFT +: rabs_pkg::PIX_W];
  end

endmodule

// ----- rtl/rabs_update.sv -----
// compare against the model, form the mask and the running average update
`timescale 1ns / 1ps

module rabs_update #(
  parameter int FRAC_W = rabs_pkg::MODEL_FRAC_DEF
) (
  input  logic                               clk,
  input  logic                               load,
  input  logic [rabs_pkg::PIX_W+FRAC_W-1:0]  rd_data,
  input  logic [rabs_pkg::PIX_W-1:0]         gray,
  input  rabs_pkg::pix_ctrl_t                ctrl_in,
  input  logic [rabs_pkg::BLEND_W-1:0]       blend_weight,
  input  logic [rabs_pkg::THRESH_W-1:0]      diff_threshold,
  output logic [rabs_pkg::PIX_W+FRAC_W-1:0]  wr_data,
  output logic [rabs_pkg::PIX_W-1:0]         mask,
  output rabs_pkg::pix_ctrl_t                ctrl_out
);

  localparam int MW = rabs_pkg::PIX_W + FRAC_W;
  localparam int BW = rabs_pkg::BLEND_W;
  localparam int PW = BW + MW;
  localparam logic [MW:0] HALF_LSB = (MW + 1)'(1) << (FRAC_W - 1);
  localparam logic [PW:0] ROUND_UP = (PW + 1)'(1) << (BW - 1);
  localparam logic [PW:0] ROUND_DN = ((PW + 1)'(1) << (BW - 1)) - (PW + 1)'(1);
  localparam logic [MW:0] MODEL_MAX = (MW + 1)'(255) << FRAC_W;

  // first stage signals
  logic [MW-1:0] g_fix;
  logic          ge;
  logic [MW-1:0] diff;
  logic [MW:0]   diff_rnd;
  logic [MW-FRAC_W:0] d_full;
  logic [rabs_pkg::PIX_W-1:0] d_sat;
  logic          fg;
  logic [PW-1:0] prod;

  // second stage registers
  logic [MW-1:0] model;
  logic [MW-1:0] g_fix_q;
  logic          ge_q;
  logic [PW-1:0] prod_q;
  logic [rabs_pkg::PIX_W-1:0] mask_q;
  rabs_pkg::pix_ctrl_t ctrl_q;

  // second stage signals
  logic [PW:0] up_sum;
  logic [PW:0] dn_sum;
  logic [MW:0] step_up;
  logic [MW:0] step_dn;
  logic [MW:0] m_up;
  logic [MW:0] m_new;

  // absolute difference, rounded and saturated distance, alpha product
  always_comb begin
    g_fix = {gray, {FRAC_W{1'b0}}};
    ge = g_fix >= rd_data;
    diff = ge ? g_fix - rd_data : rd_data - g_fix;
    diff_rnd = {1'b0, diff} + HALF_LSB;
    d_full = diff_rnd[MW:FRAC_W];
    d_sat = d_full[MW-FRAC_W] ? rabs_pkg::MASK_FG : d_full[rabs_pkg::PIX_W-1:0];
    fg = ctrl_in.loaded && (d_sat > diff_threshold);
    prod = {{MW{1'b0}}, blend_weight} * {{BW{1'b0}}, diff};
  end

  // stage register between the multiply and the write-back
  always_ff @(posedge clk) begin
    if (load) begin
      model <= rd_data;
      g_fix_q <= g_fix;
      ge_q <= ge;
      prod_q <= prod;
      mask_q <= fg ? rabs_pkg::MASK_FG : rabs_pkg::MASK_BG;
      ctrl_q <= ctrl_in;
    end
  end

  // rounded step to gray, clamped to model range; plain gray if unloaded
  always_comb begin
    up_sum = {1'b0, prod_q} + ROUND_UP;
    dn_sum = {1'b0, prod_q} + ROUND_DN;
    step_up = up_sum[PW:BW];
    step_dn = dn_sum[PW:BW];
    m_up = {1'b0, model} + step_up;
    if (ge_q) begin
      m_new = m_up;
    end else if (step_dn <= {1'b0, model}) begin
      m_new = {1'b0, model} - step_dn;
    end else begin
      m_new = '0;
    end
    if (m_new > MODEL_MAX) begin
      m_new = MODEL_MAX;
    end
    wr_data = ctrl_q.loaded ? m_new[MW-1:0] : g_fix_q;
  end

  assign mask = mask_q;
  assign ctrl_out = ctrl_q;

endmodule

// ----- rtl/running_average_background_subtract.sv -----
// top level: running average background subtraction over a frame memory
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+-------------------------------
//   pixel    | pixel_valid / pixel_stall  | blue, green, red
//   result   | result_valid / result_stall| mask, frame_end
//   config   | cfg_write_enable           | cfg_index, cfg_data
//
// one pixel per cycle unless pixel_stall is raised; read, update and result register stages.
// the model memory is read on acceptance and written back as the pixel leaves the update stage;
// a pixel whose entry is still in the pipe waits until that entry is written back,
// which only happens for frames of one or two pixels.
// reset clears the position, the first-frame flag and the pipe valids;
// the model memory gets no clearing pass, the first frame loads it.
// result_stall holds the output register and each full stage behind it; empty stages still fill.
`timescale 1ns / 1ps

module running_average_background_subtract #(
  parameter int MAX_PIXELS = rabs_pkg::MAX_PIXELS_DEF,
  parameter int MODEL_FRACTION_BITS = rabs_pkg::MODEL_FRAC_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write_enable,
  input  logic [rabs_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [rabs_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                pixel_valid,
  output logic                                pixel_stall,
  input  logic [rabs_pkg::PIX_W-1:0]          blue,
  input  logic [rabs_pkg::PIX_W-1:0]          green,
  input  logic [rabs_pkg::PIX_W-1:0]          red,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic [rabs_pkg::PIX_W-1:0]          mask,
  output logic                                frame_end
);

  localparam int MW = rabs_pkg::PIX_W + MODEL_FRACTION_BITS;
  localparam int AW = MAX_PIXELS > 1 ? $clog2(MAX_PIXELS) : 1;
  localparam int CW = (AW > rabs_pkg::FRAME_W ? AW : rabs_pkg::FRAME_W) + 1;
  localparam logic [CW-1:0] FRAME_MAX = CW'(MAX_PIXELS);

  // configuration registers
  logic [rabs_pkg::BLEND_W-1:0]  blend_weight;
  logic [rabs_pkg::THRESH_W-1:0] diff_threshold;
  logic [rabs_pkg::FRAME_W-1:0]  pixels_per_frame;

  // frame position
  logic [AW-1:0] pixel_position;
  logic          model_loaded;
  logic [CW-1:0] frame_len;
  logic [CW-1:0] pos_inc;
  logic          last;

  // pipe control
  logic          accept;
  logic          hazard;
  logic          out_en;
  logic          s2_en;
  logic          s1_en;
  logic          s1_valid;
  logic          s2_valid;
  logic [AW-1:0] s1_addr;
  logic [AW-1:0] s2_addr;
  logic [rabs_pkg::PIX_W-1:0] s1_gray;
  logic [rabs_pkg::PIX_W-1:0] gray;
  rabs_pkg::pix_ctrl_t        s1_ctrl;
  rabs_pkg::pix_ctrl_t        s2_ctrl;
  logic [MW-1:0] rd_data;
  logic [MW-1:0] wr_data;
  logic [rabs_pkg::PIX_W-1:0] s2_mask;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      blend_weight <= rabs_pkg::BLEND_RESET;
      diff_threshold <= rabs_pkg::THRESH_RESET;
      pixels_per_frame <= rabs_pkg::FRAME_RESET;
    end else if (cfg_write_enable) begin
      case (cfg_index)
        rabs_pkg::CFG_BLEND_WEIGHT: blend_weight <= cfg_data[rabs_pkg::BLEND_W-1:0];
        rabs_pkg::CFG_DIFF_THRESHOLD: diff_threshold <= cfg_data[rabs_pkg::THRESH_W-1:0];
        rabs_pkg::CFG_PIXELS_PER_FRAME: pixels_per_frame <= cfg_data[rabs_pkg::FRAME_W-1:0];
        default: ;
      endcase
    end
  end

  // frame length in use and end-of-frame test
  always_comb begin
    frame_len = CW'(pixels_per_frame);
    if (frame_len == '0) begin
      frame_len = CW'(1);
    end
    if (frame_len > FRAME_MAX) begin
      frame_len = FRAME_MAX;
    end
    pos_inc = CW'(pixel_position) + CW'(1);
    last = pos_inc >= frame_len;
  end

  // stage enables and read-after-write interlock
  always_comb begin
    out_en = !result_valid || !result_stall;
    s2_en = !s2_valid || out_en;
    s1_en = !s1_valid || s2_en;
    hazard = (s1_valid && s1_addr == pixel_position)
          || (s2_valid && s2_addr == pixel_position);
    pixel_stall = !s1_en || hazard;
    accept = pixel_valid && !pixel_stall;
  end

  // position and first-frame flag
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_position <= '0;
      model_loaded <= 1'b0;
    end else if (accept) begin
      pixel_position <= last ? '0 : pos_inc[AW-1:0];
      if (last) begin
        model_loaded <= 1'b1;
      end
    end
  end

  rabs_gray u_gray (
    .blue  (blue),
    .green (green),
    .red   (red),
    .gray  (gray)
  );

  // first stage: memory read in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_en) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_addr <= pixel_position;
      s1_gray <= gray;
      s1_ctrl.loaded <= model_loaded;
      s1_ctrl.last <= last;
    end
  end

  // second stage: update computed, write-back on leaving
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s2_en) begin
      s2_addr <= s1_addr;
    end
  end

  rabs_ram #(
    .WIDTH (MW),
    .DEPTH (MAX_PIXELS)
  ) u_model (
    .clk     (clk),
    .wr_en   (s2_valid && out_en),
    .wr_addr (s2_addr),
    .wr_data (wr_data),
    .rd_en   (accept),
    .rd_addr (pixel_position),
    .rd_data (rd_data)
  );

  rabs_update #(
    .FRAC_W (MODEL_FRACTION_BITS)
  ) u_update (
    .clk            (clk),
    .load           (s1_valid && s2_en),
    .rd_data        (rd_data),
    .gray           (s1_gray),
    .ctrl_in        (s1_ctrl),
    .blend_weight   (blend_weight),
    .diff_threshold (diff_threshold),
    .wr_data        (wr_data),
    .mask           (s2_mask),
    .ctrl_out       (s2_ctrl)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_en) begin
      result_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en && s2_valid) begin
      mask <= s2_mask;
      frame_end <= s2_ctrl.last;
    end
  end

endmodule

// ----- rtl/rabs_checker.sv -----
// port-level checker for the background subtractor, bound to the top level
`timescale 1ns / 1ps

module rabs_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        result_valid,
  input logic                        result_stall,
  input logic [rabs_pkg::PIX_W-1:0]  mask,
  input logic                        frame_end
);

  // set once the first frame has been fully delivered
  logic first_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_done <= 1'b0;
    end else if (result_valid && !result_stall && frame_end) begin
      first_done <= 1'b1;
    end
  end

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !result_valid)
    else $error("result valid right after reset");

  // mask is either foreground or background
  a_mask_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (mask == rabs_pkg::MASK_FG || mask == rabs_pkg::MASK_BG))
    else $error("mask word is neither 0 nor 255");

  // the frame that loads the model reports no foreground
  a_first_frame: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !first_done) |-> mask == rabs_pkg::MASK_BG)
    else $error("foreground reported during the loading frame");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=>
      (result_valid && $stable(mask) && $stable(frame_end)))
    else $error("stalled result word changed");

endmodule

bind running_average_background_subtract rabs_checker u_rabs_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .mask         (mask),
  .frame_end    (frame_end)
);

// ----- bench/testbench.sv -----
// self-checking bench for the running average background subtractor
`timescale 1ns / 1ps

module testbench;

  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;
  localparam int SCENE_SLOTS = 32;
  localparam int SEG_ITEMS = 50;

  // one mask word as it leaves the block
  typedef struct packed {
    logic [rabs_pkg::PIX_W-1:0] mask;
    logic frame_end;
  } mask_word_t;

  logic clk;
  logic rst;
  logic cfg_write_enable;
  logic [rabs_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [rabs_pkg::CFG_DATA_W-1:0] cfg_data;
  logic pixel_valid;
  logic pixel_stall;
  logic [rabs_pkg::PIX_W-1:0] blue;
  logic [rabs_pkg::PIX_W-1:0] green;
  logic [rabs_pkg::PIX_W-1:0] red;
  logic result_valid;
  logic result_stall;
  logic [rabs_pkg::PIX_W-1:0] mask;
  logic frame_end;

  // predictor copy of registers and state
  logic [rabs_pkg::BLEND_W-1:0] blend_q16;
  logic [rabs_pkg::THRESH_W-1:0] fg_thresh;
  logic [rabs_pkg::FRAME_W-1:0] frame_pixels;
  logic [15:0] bg_model [int unsigned];
  int unsigned pix_pos;
  bit model_ready;
  int unsigned model_span;

  mask_word_t mask_expected_q[$];
  logic [23:0] scene [0:SCENE_SLOTS-1];
  int errors;
  int sender_idle_pct;
  int stall_pct;
  bit hold_req;
  int quiet_cycles = 0;

  running_average_background_subtract i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_write_enable(cfg_write_enable),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .pixel_valid(pixel_valid),
    .pixel_stall(pixel_stall),
    .blue(blue),
    .green(green),
    .red(red),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .mask(mask),
    .frame_end(frame_end)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // gray conversion, compare against model, running average update
  function automatic mask_word_t predict_mask(input logic [7:0] b, input logic [7:0] g,
                                              input logic [7:0] r);
    int unsigned n;
    int unsigned pos;
    int unsigned gray;
    int unsigned g_fix;
    int unsigned m;
    int unsigned diff;
    int unsigned d;
    int unsigned step;
    longint unsigned prod;
    mask_word_t w;
    n = frame_pixels;
    if (n == 0) n = 1;
    if (n > rabs_pkg::MAX_PIXELS_DEF) n = rabs_pkg::MAX_PIXELS_DEF;
    pos = pix_pos;
    if (pos >= rabs_pkg::MAX_PIXELS_DEF) pos = rabs_pkg::MAX_PIXELS_DEF - 1;
    gray = (1868 * b + 9617 * g + 4899 * r + 8192) >> 14;
    g_fix = gray << rabs_pkg::MODEL_FRAC_DEF;
    w.mask = rabs_pkg::MASK_BG;
    if (!model_ready) begin
      // first frame loads the model
      bg_model[pos] = g_fix[15:0];
      if (pos + 1 > model_span) model_span = pos + 1;
    end else begin
      m = bg_model.exists(pos) ? bg_model[pos] : 0;
      diff = (g_fix >= m) ? g_fix - m : m - g_fix;
      d = (diff + (1 << (rabs_pkg::MODEL_FRAC_DEF - 1))) >> rabs_pkg::MODEL_FRAC_DEF;
      if (d > 255) d = 255;
      if (d > fg_thresh) w.mask = rabs_pkg::MASK_FG;
      prod = blend_q16;
      prod = prod * diff;
      if (g_fix >= m) begin
        step = (prod + 32768) >> 16;
        m = m + step;
      end else begin
        step = (prod + 32767) >> 16;
        m = (step <= m) ? m - step : 0;
      end
      if (m > (255 << rabs_pkg::MODEL_FRAC_DEF)) m = 255 << rabs_pkg::MODEL_FRAC_DEF;
      bg_model[pos] = m[15:0];
    end
    w.frame_end = (pos + 1 >= n);
    if (w.frame_end) begin
      pix_pos = 0;
      model_ready = 1'b1;
    end else begin
      pix_pos = pos + 1;
    end
    return w;
  endfunction

  function automatic logic [7:0] jitter(input logic [7:0] v);
    int t;
    t = v;
    t = t + int'($urandom_range(8)) - 4;
    if (t < 0) t = 0;
    if (t > 255) t = 255;
    return t[7:0];
  endfunction

  // mostly a static scene with sensor noise, sometimes motion
  function automatic logic [23:0] scene_pixel();
    int unsigned slot;
    int unsigned roll;
    logic [23:0] p;
    slot = pix_pos % SCENE_SLOTS;
    roll = $urandom_range(99);
    p = scene[slot];
    if (roll < 55) begin
      p = {jitter(p[23:16]), jitter(p[15:8]), jitter(p[7:0])};
    end else if (roll >= 80) begin
      p = 24'($urandom);
      if (roll < 88) scene[slot] = p;
    end
    return p;
  endfunction

  // offer one pixel word and record its expected mask once accepted
  task automatic push_pixel(input logic [23:0] bgr);
    int gap;
    gap = 0;
    while (gap < 16 && $urandom_range(99) < sender_idle_pct) gap++;
    @(negedge clk);
    while (gap > 0) begin
      pixel_valid <= 1'b0;
      @(negedge clk);
      gap--;
    end
    pixel_valid <= 1'b1;
    blue <= bgr[23:16];
    green <= bgr[15:8];
    red <= bgr[7:0];
    do @(posedge clk); while (pixel_stall);
    mask_expected_q.push_back(predict_mask(bgr[23:16], bgr[15:8], bgr[7:0]));
  endtask

  // stop sending and let every outstanding mask word come back
  task automatic wait_drained();
    @(negedge clk);
    pixel_valid <= 1'b0;
    while (mask_expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [rabs_pkg::CFG_INDEX_W-1:0] idx,
                           input int unsigned value);
    @(negedge clk);
    cfg_write_enable <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[rabs_pkg::CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_write_enable <= 1'b0;
    case (idx)
      rabs_pkg::CFG_BLEND_WEIGHT: begin
        blend_q16 = value[rabs_pkg::BLEND_W-1:0];
      end
      rabs_pkg::CFG_DIFF_THRESHOLD: begin
        fg_thresh = value[rabs_pkg::THRESH_W-1:0];
      end
      rabs_pkg::CFG_PIXELS_PER_FRAME: begin
        frame_pixels = value[rabs_pkg::FRAME_W-1:0];
      end
      default: begin
      end
    endcase
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    sender_idle_pct = send_pct;
    stall_pct = recv_pct;
  endtask

  // first frame with an oversized frame setting loads the model
  task automatic test_first_frame();
    write_reg(rabs_pkg::CFG_BLEND_WEIGHT, rabs_pkg::BLEND_RESET);
    write_reg(rabs_pkg::CFG_DIFF_THRESHOLD, rabs_pkg::THRESH_RESET);
    write_reg(rabs_pkg::CFG_PIXELS_PER_FRAME, 20'hfffff);
    push_pixel(24'h000000);
    push_pixel(24'hffffff);
    push_pixel(24'hff0000);
    push_pixel(24'h00ff00);
    push_pixel(24'h0000ff);
    push_pixel(24'h808080);
    repeat (24) push_pixel(scene_pixel());
    wait_drained();
  endtask

  // frame size cut below the current position ends the frame at once
  task automatic test_shrink_mid_frame();
    write_reg(rabs_pkg::CFG_PIXELS_PER_FRAME, 8);
    push_pixel(scene_pixel());
    repeat (8) push_pixel(scene_pixel());
    wait_drained();
  endtask

  // threshold and learning rate at both ends
  task automatic test_threshold_extremes();
    write_reg(rabs_pkg::CFG_PIXELS_PER_FRAME, 4);
    write_reg(rabs_pkg::CFG_BLEND_WEIGHT, 0);
    write_reg(rabs_pkg::CFG_DIFF_THRESHOLD, 0);
    push_pixel(24'hffffff);
    push_pixel(24'h000000);
    push_pixel(24'hff0000);
    push_pixel(24'h00ff00);
    wait_drained();
    write_reg(rabs_pkg::CFG_BLEND_WEIGHT, 16'hffff);
    write_reg(rabs_pkg::CFG_DIFF_THRESHOLD, 8'hff);
    push_pixel(24'h000000);
    push_pixel(24'hffffff);
    push_pixel(24'h000000);
    push_pixel(24'hffffff);
    wait_drained();
    write_reg(rabs_pkg::CFG_DIFF_THRESHOLD, 0);
    push_pixel(24'hffffff);
    push_pixel(24'h000000);
    push_pixel(24'hffffff);
    push_pixel(24'h000000);
    wait_drained();
  endtask

  // zero, one and two pixel frames reuse model entries still in the pipe
  task automatic test_tiny_frames();
    int unsigned size;
    write_reg(rabs_pkg::CFG_BLEND_WEIGHT, $urandom_range(16'hffff));
    write_reg(rabs_pkg::CFG_DIFF_THRESHOLD, $urandom_range(40));
    for (size = 0; size <= 2; size++) begin
      write_reg(rabs_pkg::CFG_PIXELS_PER_FRAME, size);
      repeat (12) push_pixel(scene_pixel());
      wait_drained();
    end
  endtask

  // random settings and scene content under each idling pattern
  task automatic test_random_phases();
    int ph;
    int seg;
    int unsigned roll;
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_idling(0, 0);
        1: set_idling(50, 0);
        2: set_idling(0, 50);
        default: set_idling(11, 11);
      endcase
      for (seg = 0; seg < 7; seg++) begin
        wait_drained();
        roll = $urandom_range(9);
        if (roll == 0) write_reg(rabs_pkg::CFG_BLEND_WEIGHT, 0);
        else if (roll == 1) write_reg(rabs_pkg::CFG_BLEND_WEIGHT, 16'hffff);
        else write_reg(rabs_pkg::CFG_BLEND_WEIGHT, $urandom_range(16'hffff));
        roll = $urandom_range(9);
        if (roll == 0) write_reg(rabs_pkg::CFG_DIFF_THRESHOLD, 0);
        else if (roll == 1) write_reg(rabs_pkg::CFG_DIFF_THRESHOLD, 8'hff);
        else if (roll < 4) write_reg(rabs_pkg::CFG_DIFF_THRESHOLD, $urandom_range(8'hff));
        else write_reg(rabs_pkg::CFG_DIFF_THRESHOLD, $urandom_range(40));
        // never grow past the entries the first frame wrote
        write_reg(rabs_pkg::CFG_PIXELS_PER_FRAME, $urandom_range(model_span, 0));
        repeat (SEG_ITEMS) push_pixel(scene_pixel());
      end
    end
    wait_drained();
  endtask

  // long receiver hold-off while the sender keeps pushing
  task automatic test_backpressure();
    set_idling(0, 0);
    write_reg(rabs_pkg::CFG_PIXELS_PER_FRAME, model_span);
    hold_req = 1'b1;
    repeat (60) push_pixel(scene_pixel());
    wait_drained();
  endtask

  // sender bursts, then pauses until every mask word is back
  task automatic test_drain_pause();
    set_idling(11, 11);
    repeat (3) begin
      repeat (15) push_pixel(scene_pixel());
      wait_drained();
    end
  endtask

  // receiver stall generation
  initial begin
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      result_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // compare each accepted mask word with the oldest expectation
  always @(posedge clk) begin : check_word
    mask_word_t want;
    if (!rst && result_valid && !result_stall) begin
      if (mask_expected_q.size() == 0) begin
        $error("mask word with no pixel outstanding: mask %0d frame_end %0d", mask, frame_end);
        errors++;
      end else begin
        want = mask_expected_q.pop_front();
        if (mask !== want.mask) begin
          $error("mask expected %0d actual %0d", want.mask, mask);
          errors++;
        end
        if (frame_end !== want.frame_end) begin
          $error("frame_end expected %0d actual %0d", want.frame_end, frame_end);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk) begin
    if (rst || (pixel_valid && !pixel_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int i;
    rst = 1'b1;
    cfg_write_enable = 1'b0;
    cfg_index = rabs_pkg::CFG_BLEND_WEIGHT;
    cfg_data = '0;
    pixel_valid = 1'b0;
    blue = '0;
    green = '0;
    red = '0;
    hold_req = 1'b0;
    errors = 0;
    sender_idle_pct = 0;
    stall_pct = 0;
    blend_q16 = rabs_pkg::BLEND_RESET;
    fg_thresh = rabs_pkg::THRESH_RESET;
    frame_pixels = rabs_pkg::FRAME_RESET;
    pix_pos = 0;
    model_ready = 1'b0;
    model_span = 0;
    for (i = 0; i < SCENE_SLOTS; i++) scene[i] = 24'($urandom);
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_first_frame();
    test_shrink_mid_frame();
    test_threshold_extremes();
    test_tiny_frames();
    test_random_phases();
    test_backpressure();
    test_drain_pause();

    wait_drained();
    repeat (10) @(posedge clk);
    if (errors == 0 && mask_expected_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/rabs_pkg.sv
rtl/rabs_ram.sv
rtl/rabs_gray.sv
rtl/rabs_update.sv
rtl/running_average_background_subtract.sv
rtl/rabs_checker.sv
bench/testbench.sv
